/* hdl/sws_pkg.sv */
// shared types and constants for the sliding window counter sum block
`default_nettype none
package sws_pkg;

  // default sizing
  localparam int DEFAULT_WINDOW_DEPTH = 16;
  localparam int DEFAULT_COUNTER_BITS = 16;

  // fixed field widths of the ports
  localparam int OPERATION_W = 2;
  localparam int VALUE_W     = 16;
  localparam int NEWEST_W    = 16;
  localparam int TOTAL_W     = 20;
  localparam int ENTRIES_W   = 5;
  localparam int WLEN_W      = 5;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;

  // operation codes
  localparam logic [OPERATION_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OPERATION_W-1:0] OP_ADD  = 2'd1;
  localparam logic [OPERATION_W-1:0] OP_SET  = 2'd2;

  // register indexes
  localparam logic REG_WINDOW_LENGTH = 1'b0;

  // reset value of the window length register
  localparam logic [WLEN_W-1:0] WLEN_RESET = 5'd1;

  // one result transaction
  typedef struct packed {
    logic [NEWEST_W-1:0]  newest_count;
    logic [TOTAL_W-1:0]   window_total;
    logic [ENTRIES_W-1:0] entries_held;
  } sws_result_t;

endpackage
`default_nettype wire

/* hdl/sliding_window_counter_sum.sv */
// top level of the sliding window counter sum block
`default_nettype none
// sliding window of per-interval counters with a running window total.
// each input transaction carries one operation: push opens a new newest slot
// with the value (evicting the oldest slot first once the entry count has
// reached window_length or the window depth), add adds the value to the
// newest slot saturating at the counter maximum, set overwrites the newest
// slot; any other code leaves the state alone. every transaction returns one
// result with the newest slot, the window total and the entry count. the
// entry count never shrinks when window_length is lowered. after reset the
// window holds one zero entry. one transaction is taken every clock cycle
// while the output buffer is not full: the newest slot, the total and the
// ring pointers live in flops, and the slot memory is written once per
// transaction while its single read port prefetches the oldest slot for
// the next eviction, so back-to-back transactions do not stall. results are
// registered in a two-entry output buffer that lets one more transaction in
// while a result is stalled. window_length is written over the apb port at
// byte address 0 and must only be changed while the block is idle.
module sliding_window_counter_sum import sws_pkg::*; #(
  parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH,
  parameter int COUNTER_BITS = DEFAULT_COUNTER_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // apb configuration port
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [APB_ADDR_W-1:0]  paddr,
  input  wire logic [APB_DATA_W-1:0]  pwdata,
  output logic      [APB_DATA_W-1:0]  prdata,
  output logic                        pready,
  // input channel
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [OPERATION_W-1:0] operation,
  input  wire logic [VALUE_W-1:0]     value,
  // output channel
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic      [NEWEST_W-1:0]    newest_count,
  output logic      [TOTAL_W-1:0]     window_total,
  output logic      [ENTRIES_W-1:0]   entries_held
);

  localparam int IDX_W      = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int HELD_W     = $clog2(WINDOW_DEPTH + 1);
  localparam int TOTAL_BITS = COUNTER_BITS + HELD_W;
  localparam logic [63:0] COUNTER_MAX = (64'd1 << COUNTER_BITS) - 64'd1;
  localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(WINDOW_DEPTH - 1);
  localparam logic [HELD_W-1:0] DEPTH_HELD = HELD_W'(WINDOW_DEPTH);

  // configuration register
  logic [WLEN_W-1:0] window_length;
  logic              cfg_write;

  // window state
  logic [COUNTER_BITS-1:0] newest;
  logic [COUNTER_BITS-1:0] newest_next;
  logic [IDX_W-1:0]        oldest_idx;
  logic [IDX_W-1:0]        oldest_idx_next;
  logic [IDX_W-1:0]        newest_idx;
  logic [IDX_W-1:0]        newest_idx_next;
  logic [HELD_W-1:0]       held;
  logic [HELD_W-1:0]       held_next;
  logic [TOTAL_BITS-1:0]   total;
  logic [TOTAL_BITS-1:0]   total_next;

  // datapath helpers
  logic                    accept;
  logic                    buf_full;
  logic [COUNTER_BITS-1:0] oldest_val;
  logic [COUNTER_BITS-1:0] value_clamped;
  logic [63:0]             value_ext;
  logic [COUNTER_BITS:0]   add_sum;
  logic [COUNTER_BITS-1:0] add_sat;
  logic                    evict;
  logic [IDX_W-1:0]        oldest_idx_inc;
  logic [IDX_W-1:0]        newest_idx_inc;
  logic [63:0]             newest_ext;
  logic [63:0]             total_ext;
  logic [63:0]             held_ext;
  sws_result_t             result;
  sws_result_t             out_data;

  // apb: always ready, one register at index 0
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_WINDOW_LENGTH) begin
      prdata = APB_DATA_W'(window_length);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WLEN_RESET;
    end else if (cfg_write && (paddr[2] == REG_WINDOW_LENGTH)) begin
      window_length <= pwdata[WLEN_W-1:0];
    end
  end

  // input handshake, held off only when the output buffer is full
  assign in_stall = buf_full;
  assign accept   = in_valid && !in_stall;

  // value clamped to the counter range
  assign value_ext     = 64'(value);
  assign value_clamped = (value_ext > COUNTER_MAX) ? COUNTER_MAX[COUNTER_BITS-1:0]
                                                   : value_ext[COUNTER_BITS-1:0];

  // saturating add to the newest slot
  assign add_sum = {1'b0, newest} + {1'b0, value_clamped};
  assign add_sat = add_sum[COUNTER_BITS] ? COUNTER_MAX[COUNTER_BITS-1:0]
                                         : add_sum[COUNTER_BITS-1:0];

  // a push evicts once the count reaches the window length or the depth
  assign evict = (32'(held) >= 32'(window_length)) || (held >= DEPTH_HELD);

  // ring pointer increments
  assign oldest_idx_inc = (oldest_idx == LAST_IDX) ? '0 : oldest_idx + IDX_W'(1);
  assign newest_idx_inc = (newest_idx == LAST_IDX) ? '0 : newest_idx + IDX_W'(1);

  always_comb begin
    newest_next     = newest;
    oldest_idx_next = oldest_idx;
    newest_idx_next = newest_idx;
    held_next       = held;
    total_next      = total;
    case (operation)
      OP_PUSH: begin
        newest_next     = value_clamped;
        newest_idx_next = newest_idx_inc;
        if (evict) begin
          // the oldest slot leaves, the new slot takes the freed place
          oldest_idx_next = oldest_idx_inc;
          total_next      = total - TOTAL_BITS'(oldest_val) + TOTAL_BITS'(value_clamped);
        end else begin
          held_next  = held + HELD_W'(1);
          total_next = total + TOTAL_BITS'(value_clamped);
        end
      end
      OP_ADD: begin
        newest_next = add_sat;
        total_next  = total - TOTAL_BITS'(newest) + TOTAL_BITS'(add_sat);
      end
      OP_SET: begin
        newest_next = value_clamped;
        total_next  = total - TOTAL_BITS'(newest) + TOTAL_BITS'(value_clamped);
      end
      default: begin
        // unused code, state unchanged
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      newest     <= '0;
      oldest_idx <= '0;
      newest_idx <= '0;
      held       <= HELD_W'(1);
      total      <= '0;
    end else if (accept) begin
      newest     <= newest_next;
      oldest_idx <= oldest_idx_next;
      newest_idx <= newest_idx_next;
      held       <= held_next;
      total      <= total_next;
    end
  end

  // slot memory: newest slot written back every transaction, oldest
  // slot of the updated window prefetched for the next eviction
  sws_slot_store #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_slot_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_addr (newest_idx_next),
    .wr_data (newest_next),
    .rd_en   (accept),
    .rd_addr (oldest_idx_next),
    .rd_data (oldest_val)
  );

  // result from the updated state, fitted to the port widths
  assign newest_ext = 64'(newest_next);
  assign total_ext  = 64'(total_next);
  assign held_ext   = 64'(held_next);

  always_comb begin
    result.newest_count = newest_ext[NEWEST_W-1:0];
    result.window_total = total_ext[TOTAL_W-1:0];
    result.entries_held = held_ext[ENTRIES_W-1:0];
  end

  sws_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign newest_count = out_data.newest_count;
  assign window_total = out_data.window_total;
  assign entries_held = out_data.entries_held;

endmodule
`default_nettype wire

/* hdl/sws_slot_store.sv */
// slot memory with registered read of the oldest slot and write forwarding
`default_nettype none
module sws_slot_store import sws_pkg::*; #(
  parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH,
  parameter int COUNTER_BITS = DEFAULT_COUNTER_BITS,
  localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    wr_en,
  input  wire logic [IDX_W-1:0]        wr_addr,
  input  wire logic [COUNTER_BITS-1:0] wr_data,
  input  wire logic                    rd_en,
  input  wire logic [IDX_W-1:0]        rd_addr,
  output logic      [COUNTER_BITS-1:0] rd_data
);

  logic [COUNTER_BITS-1:0] mem [WINDOW_DEPTH];

  // slot 0 holds the single zero entry of the window after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      mem[0] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, same-cycle write to the read address wins
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_data <= '0;
    end else if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/sws_out_buf.sv */
// two-entry output buffer that decouples the result port from the input
`default_nettype none
module sws_out_buf import sws_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire sws_result_t push_data,
  output logic             full,
  output logic             out_valid,
  input  wire logic        out_stall,
  output sws_result_t      out_data
);

  logic        head_valid;
  logic        skid_valid;
  sws_result_t skid_data;
  logic        pop;

  assign pop       = head_valid && !out_stall;
  assign out_valid = head_valid;
  assign full      = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (pop) begin
          skid_valid <= 1'b0;
        end
      end else if (head_valid) begin
        if (push && !pop) begin
          skid_valid <= 1'b1;
        end else if (!push && pop) begin
          head_valid <= 1'b0;
        end
      end else if (push) begin
        head_valid <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (!head_valid || pop) begin
        out_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end
  end

endmodule
`default_nettype wire

/* dv/window_sum_checker.sv */
// checker for the sliding window counter sum block: predicts every result and compares it
module window_sum_checker import sws_pkg::*; #(
  parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [APB_ADDR_W-1:0]  paddr,
  input  wire logic [APB_DATA_W-1:0]  pwdata,
  input  wire logic                   pready,
  input  wire logic                   in_valid,
  input  wire logic                   in_stall,
  input  wire logic [OPERATION_W-1:0] operation,
  input  wire logic [VALUE_W-1:0]     value,
  input  wire logic                   out_valid,
  input  wire logic                   out_stall,
  input  wire logic [NEWEST_W-1:0]    newest_count,
  input  wire logic [TOTAL_W-1:0]     window_total,
  input  wire logic [ENTRIES_W-1:0]   entries_held,
  output int                          fail_count,
  output int                          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [NEWEST_W-1:0]   COUNT_MAX = '1;
  localparam logic [APB_ADDR_W-1:0] WLEN_ADDR = APB_ADDR_W'(4 * REG_WINDOW_LENGTH);

  // shadow of the window state
  logic [NEWEST_W-1:0]  slot_val [WINDOW_DEPTH];
  int                   oldest_pos;
  logic [ENTRIES_W-1:0] held_cnt;
  logic [TOTAL_W-1:0]   total_sum;
  logic [WLEN_W-1:0]    wlen_shadow;

  sws_result_t window_expect_q[$];
  sws_result_t got;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  function automatic int newest_pos();
    return (oldest_pos + int'(held_cnt) - 1) % WINDOW_DEPTH;
  endfunction

  task automatic overwrite_newest(input logic [NEWEST_W-1:0] v);
    int n;
    begin
      n = newest_pos();
      total_sum = total_sum - TOTAL_W'(slot_val[n]) + TOTAL_W'(v);
      slot_val[n] = v;
    end
  endtask

  task automatic clear_window();
    foreach (slot_val[k]) slot_val[k] = '0;
    oldest_pos  = 0;
    held_cnt    = ENTRIES_W'(1);
    total_sum   = '0;
    wlen_shadow = WLEN_RESET;
  endtask

  // one operation on the shadow window, returning what the block must report
  task automatic advance_window(input logic [OPERATION_W-1:0] op,
                                input logic [VALUE_W-1:0] v,
                                output sws_result_t res);
    logic [NEWEST_W:0] sum;
    begin
      if (op == OP_PUSH) begin
        if (held_cnt >= wlen_shadow || int'(held_cnt) >= WINDOW_DEPTH) begin
          total_sum = total_sum - TOTAL_W'(slot_val[oldest_pos]);
          slot_val[oldest_pos] = '0;
          oldest_pos = (oldest_pos + 1) % WINDOW_DEPTH;
        end else begin
          held_cnt = held_cnt + 1'b1;
          slot_val[newest_pos()] = '0;
        end
        overwrite_newest(v);
      end else if (op == OP_ADD) begin
        sum = {1'b0, slot_val[newest_pos()]} + {1'b0, v};
        overwrite_newest(sum > {1'b0, COUNT_MAX} ? COUNT_MAX : sum[NEWEST_W-1:0]);
      end else if (op == OP_SET) begin
        overwrite_newest(v);
      end
      res.newest_count = slot_val[newest_pos()];
      res.window_total = total_sum;
      res.entries_held = held_cnt;
    end
  endtask

  always @(posedge clk) begin
    sws_result_t want;
    sws_result_t pred;
    if (rst) begin
      clear_window();
      window_expect_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == WLEN_ADDR)
        wlen_shadow = pwdata[WLEN_W-1:0];
      if (out_valid && !out_stall) begin
        got.newest_count = newest_count;
        got.window_total = window_total;
        got.entries_held = entries_held;
        if (window_expect_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: newest %0d total %0d entries %0d",
                     got.newest_count, got.window_total, got.entries_held);
        end else begin
          want = window_expect_q.pop_front();
          if (got.newest_count !== want.newest_count ||
              got.window_total !== want.window_total ||
              got.entries_held !== want.entries_held) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: newest %0d/%0d total %0d/%0d entries %0d/%0d (exp/act)",
                       want.newest_count, got.newest_count,
                       want.window_total, got.window_total,
                       want.entries_held, got.entries_held);
          end
        end
      end
      if (in_valid && !in_stall) begin
        advance_window(operation, value, pred);
        window_expect_q.insert(window_expect_q.size(), pred);
      end
    end
    outstanding <= window_expect_q.size();
  end

endmodule

/* dv/tb_top.sv */
// top of the testbench: clock, reset, stimulus and verdict for the sliding window block
module tb_top;
  import sws_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // code the block must ignore
  localparam logic [OPERATION_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [APB_ADDR_W-1:0]  WLEN_ADDR = APB_ADDR_W'(4 * REG_WINDOW_LENGTH);
  localparam int PHASE_COUNT   = 7;
  localparam int PHASE_ITEMS   = 150;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT   = 300000;

  logic                   clk;
  logic                   rst;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [APB_ADDR_W-1:0]  paddr;
  logic [APB_DATA_W-1:0]  pwdata;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;
  logic                   in_valid;
  logic                   in_stall;
  logic [OPERATION_W-1:0] operation;
  logic [VALUE_W-1:0]     value;
  logic                   out_valid;
  logic                   out_stall;
  logic [NEWEST_W-1:0]    newest_count;
  logic [TOTAL_W-1:0]     window_total;
  logic [ENTRIES_W-1:0]   entries_held;

  int          fail_count;
  int          outstanding;
  int unsigned cycle_count;
  int          sent_count;
  int          config_count;
  int          stall_left;
  bit          bursts_on;

  sliding_window_counter_sum i_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .newest_count (newest_count),
    .window_total (window_total),
    .entries_held (entries_held)
  );

  window_sum_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .newest_count (newest_count),
    .window_total (window_total),
    .entries_held (entries_held),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side back-pressure: random stall bursts while bursts are enabled
  initial begin
    out_stall  = 1'b0;
    stall_left = 0;
  end
  always @(posedge clk) begin
    if (!bursts_on) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // offer one transaction, with an optional idle burst first, and hold it until taken
  task automatic send_item(input logic [OPERATION_W-1:0] op, input logic [VALUE_W-1:0] v);
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    value     <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  // stop sending and wait for every predicted result, then let the pipe settle
  task automatic drain_window();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write: setup cycle, then access cycle until pready
  task automatic write_wlen(input int unsigned wl);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= WLEN_ADDR;
    pwdata  <= APB_DATA_W'(wl);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    config_count++;
  endtask

  // random values lean on the edges so that saturation and zero slots show up
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return VALUE_W'($urandom_range(0, 15));
      4, 5:    return VALUE_W'($urandom_range(16'hF000, 16'hFFFF));
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // mostly pushes and adds, with sets and the odd unused code
  function automatic logic [OPERATION_W-1:0] pick_op();
    int r;
    r = $urandom_range(0, 19);
    if (r < 8)
      return OP_PUSH;
    else if (r < 13)
      return OP_ADD;
    else if (r < 18)
      return OP_SET;
    else
      return OP_UNUSED;
  endfunction

  initial begin
    int unsigned wlen_plan [PHASE_COUNT];
    sent_count   = 0;
    config_count = 0;
    bursts_on    = 1'b0;
    rst       <= 1'b1;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    in_valid  <= 1'b0;
    operation <= OP_PUSH;
    value     <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // directed: window length at its reset value of one
    send_item(OP_UNUSED, '1);     // ignored code still reports the state
    send_item(OP_ADD, '1);
    send_item(OP_ADD, VALUE_W'(1)); // saturates the newest slot
    send_item(OP_SET, '0);
    send_item(OP_SET, '1);
    send_item(OP_PUSH, '0);       // full window, oldest slot evicted
    drain_window();

    // short window filled past its length with maximum values
    write_wlen(4);
    repeat (5) send_item(OP_PUSH, '1);
    send_item(OP_ADD, VALUE_W'(1));
    send_item(OP_UNUSED, '0);
    drain_window();

    // window length lowered below the count: count must hold
    write_wlen(2);
    send_item(OP_PUSH, VALUE_W'(1));
    send_item(OP_PUSH, VALUE_W'(2));
    drain_window();

    // zero window length: every push evicts
    write_wlen(0);
    send_item(OP_PUSH, VALUE_W'(7));
    send_item(OP_ADD, VALUE_W'(16'h8000));
    drain_window();

    // random phases over several window lengths, the extremes among them
    wlen_plan[0] = 16;
    wlen_plan[1] = 31;
    wlen_plan[2] = 3;
    wlen_plan[3] = 0;
    wlen_plan[4] = $urandom_range(1, 16);
    wlen_plan[5] = $urandom_range(0, 31);
    wlen_plan[6] = 16;
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      write_wlen(wlen_plan[ph]);
      // one phase runs without bursts, and the final one too
      bursts_on = (ph != 2 && ph != PHASE_COUNT - 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_item(pick_op(), pick_value());
        // hold off mid-phase until the block has caught up
        if (i == PHASE_ITEMS / 2 && ph == 1)
          drain_window();
      end
      drain_window();
    end

    bursts_on = 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d transactions over %0d window length writes,", sent_count,
             config_count);
    $display("push/add/set/unused codes with idle and stall bursts on both sides");
    if (fail_count == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/sws_pkg.sv
hdl/sws_slot_store.sv
hdl/sws_out_buf.sv
hdl/sliding_window_counter_sum.sv
dv/window_sum_checker.sv
dv/tb_top.sv
